// ===== sv/sorted_timer_queue_unit_defines.svh =====
// Assertion macros for the checker of the timer queue.
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ===== sv/stq_pkg.sv =====
package stq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 48;

  // Fixed field widths of the stream payloads.
  localparam int TIME_FIELD_BITS = 48;
  localparam int IVL_BITS        = 32;
  localparam int ID_BITS         = 16;
  localparam int IN_DATA_BITS    = TIME_FIELD_BITS + IVL_BITS + ID_BITS;

  // Register port geometry; the register index is paddr[2].
  localparam int  APB_ADDR_BITS = 3;
  localparam int  APB_DATA_BITS = 32;
  localparam logic REG_REFRESH  = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_EXPIRED   = 2'd0,
    ST_CANCELLED = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_REMOVE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXPIRE,
    S_ACTION
  } state_t;

  // Status that the chain reports to the controller.
  typedef struct packed {
    logic head_due;
    logic second_due;
    logic full;
    logic found;
  } chain_stat_t;

endpackage

// ===== sv/stq_cell.sv =====
module stq_cell
  import stq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_cmd_t            cmd,
  input  logic [TIME_BITS-1:0] new_dl,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic                 prev_valid,
  input  logic [TIME_BITS-1:0] prev_dl,
  input  logic [ID_BITS-1:0]   prev_id,
  input  logic                 prev_keep,
  input  logic                 prev_seen,
  input  logic                 next_valid,
  input  logic [TIME_BITS-1:0] next_dl,
  input  logic [ID_BITS-1:0]   next_id,
  output logic                 valid,
  output logic [TIME_BITS-1:0] dl,
  output logic [ID_BITS-1:0]   id,
  output logic                 keep,
  output logic                 seen
);

  logic                 valid_next;
  logic [TIME_BITS-1:0] dl_next;
  logic [ID_BITS-1:0]   id_next;

  // The entry stays put on insertion when the new deadline is not earlier,
  // so equal deadlines keep their order. The seen flag is set from the first match on.
  assign keep = valid && !(new_dl < dl);
  assign seen = prev_seen || (valid && (id == new_id));

  // Choose between keeping, taking the new entry and shifting a neighbour.
  always_comb begin
    valid_next = valid;
    dl_next    = dl;
    id_next    = id;
    unique case (cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        if (keep) begin
        end else if (prev_keep) begin
          valid_next = 1'b1;
          dl_next    = new_dl;
          id_next    = new_id;
        end else begin
          valid_next = prev_valid;
          dl_next    = prev_dl;
          id_next    = prev_id;
        end
      end
      CMD_POP: begin
        valid_next = next_valid;
        dl_next    = next_dl;
        id_next    = next_id;
      end
      CMD_REMOVE: begin
        if (seen) begin
          valid_next = next_valid;
          dl_next    = next_dl;
          id_next    = next_id;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    dl <= dl_next;
    id <= id_next;
  end

endmodule

// ===== sv/stq_chain.sv =====
module stq_chain
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_cmd_t            cmd,
  input  logic [TIME_BITS-1:0] new_dl,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TIME_BITS-1:0] now,
  output logic [ID_BITS-1:0]   head_id,
  output chain_stat_t          stat
);

  logic                 valid_w [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] dl_w    [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   id_w    [QUEUE_DEPTH];
  logic                 keep_w  [QUEUE_DEPTH];
  logic                 seen_w  [QUEUE_DEPTH];

  // Row of cells, entry 0 holding the earliest deadline.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 p_valid;
    logic [TIME_BITS-1:0] p_dl;
    logic [ID_BITS-1:0]   p_id;
    logic                 p_keep;
    logic                 p_seen;
    logic                 n_valid;
    logic [TIME_BITS-1:0] n_dl;
    logic [ID_BITS-1:0]   n_id;

    if (i == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_dl    = '0;
      assign p_id    = '0;
      assign p_keep  = 1'b1;
      assign p_seen  = 1'b0;
    end else begin : g_inner_prev
      assign p_valid = valid_w[i-1];
      assign p_dl    = dl_w[i-1];
      assign p_id    = id_w[i-1];
      assign p_keep  = keep_w[i-1];
      assign p_seen  = seen_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_dl    = '0;
      assign n_id    = '0;
    end else begin : g_inner_next
      assign n_valid = valid_w[i+1];
      assign n_dl    = dl_w[i+1];
      assign n_id    = id_w[i+1];
    end

    stq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_dl    (new_dl),
      .new_id    (new_id),
      .prev_valid(p_valid),
      .prev_dl   (p_dl),
      .prev_id   (p_id),
      .prev_keep (p_keep),
      .prev_seen (p_seen),
      .next_valid(n_valid),
      .next_dl   (n_dl),
      .next_id   (n_id),
      .valid     (valid_w[i]),
      .dl        (dl_w[i]),
      .id        (id_w[i]),
      .keep      (keep_w[i]),
      .seen      (seen_w[i])
    );
  end

  // The two front entries are checked against the stored time.
  assign head_id         = id_w[0];
  assign stat.head_due   = valid_w[0] && (dl_w[0] < now);
  assign stat.second_due = valid_w[1] && (dl_w[1] < now);
  assign stat.full       = valid_w[QUEUE_DEPTH-1];
  assign stat.found      = seen_w[QUEUE_DEPTH-1];

endmodule

// ===== sv/sorted_timer_queue_unit.sv =====
// Sorted timer queue. Requests arrive on the s_* stream: s_tuser carries the
// opcode (tick, start, cancel) and s_tdata the time, interval and timer id.
// Results leave on the m_* stream, one per transaction: m_tdata is the timer
// id, m_tuser the status and m_tlast marks the final result of a request.
// The single register (refresh on request) is written over the APB port.
// Pending timers sit in a row of cells sorted by deadline; an insertion or
// removal acts on the whole row at once, and the front cell is
// compared with the stored time.
// A start or cancel without refresh goes from idle straight to the action
// step. A tick expires due timers one per cycle from the front cell while
// the output is free; a start or cancel with refresh expires them first. One
// request is worked on at a time and s_tready is high only between requests.
// Results are held in an output register: while m_tready is low the held
// result stays unchanged and no new result is loaded. Reset empties the queue,
// zeroes the stored time and clears the register; the block is ready as soon
// as reset is released.
module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [47:0] current_time, [79:48] interval_us, [95:80] timer identifier
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [15:0] result_id
  output logic [ID_BITS-1:0]       m_tdata,
  // [1:0] status
  output logic [1:0]               m_tuser,
  output logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  state_t               state;
  state_t               state_next;
  logic                 refresh_en;
  logic [1:0]           op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] dl_q;
  logic [TIME_BITS-1:0] now;

  logic [TIME_BITS-1:0] in_time;
  logic [IVL_BITS-1:0]  in_ivl;
  logic [ID_BITS-1:0]   in_id;
  logic                 in_fire;
  logic                 in_refresh;
  logic [TIME_BITS-1:0] dl_base;
  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] dl_calc;

  cell_cmd_t            cmd;
  chain_stat_t          stat;
  logic [ID_BITS-1:0]   head_id;
  logic                 out_free;
  logic                 load_out;
  status_t              out_status;
  logic [ID_BITS-1:0]   out_id;
  logic                 out_last;

  // Register port: one register, written on the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REFRESH) ?
                  {{(APB_DATA_BITS-1){1'b0}}, refresh_en} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_en <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REFRESH)) begin
      refresh_en <= pwdata[0];
    end
  end

  // Request fields.
  assign in_time = s_tdata[TIME_BITS-1:0];
  assign in_ivl  = s_tdata[TIME_FIELD_BITS +: IVL_BITS];
  assign in_id   = s_tdata[TIME_FIELD_BITS+IVL_BITS +: ID_BITS];
  assign in_fire = s_tvalid && s_tready;

  // A tick, or a start or cancel with refresh, loads the request's time.
  assign in_refresh = (s_tuser == OP_TICK) ||
                      (refresh_en && ((s_tuser == OP_START) || (s_tuser == OP_CANCEL)));

  // Deadline of a started timer, saturated to the time width.
  assign dl_base = in_refresh ? in_time : now;
  assign dl_sum  = (TIME_BITS+1)'(dl_base) + (TIME_BITS+1)'(in_ivl);
  assign dl_calc = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];

  // Request capture and stored time.
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (in_fire && in_refresh) begin
      now <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= s_tuser;
      id_q <= in_id;
      dl_q <= dl_calc;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_TICK) begin
            state_next = S_EXPIRE;
          end else if ((s_tuser == OP_START) || (s_tuser == OP_CANCEL)) begin
            state_next = refresh_en ? S_EXPIRE : S_ACTION;
          end
        end
      end
      S_EXPIRE: begin
        if (!stat.head_due) begin
          state_next = (op_q == OP_TICK) ? S_IDLE : S_ACTION;
        end
      end
      S_ACTION: begin
        if ((op_q == OP_START) && !stat.full) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the state machine: chain command and result to send.
  always_comb begin
    s_tready   = 1'b0;
    cmd        = CMD_HOLD;
    load_out   = 1'b0;
    out_status = ST_EXPIRED;
    out_id     = head_id;
    out_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // No request is taken while reset is held.
        s_tready = !rst;
      end
      S_EXPIRE: begin
        // One due timer leaves the front per cycle while the output is free;
        // a cancel always follows with its own result; a start cannot be full after a pop.
        if (stat.head_due && out_free) begin
          cmd      = CMD_POP;
          load_out = 1'b1;
          out_last = !stat.second_due && (op_q != OP_CANCEL);
        end
      end
      S_ACTION: begin
        out_id = id_q;
        if (op_q == OP_START) begin
          if (!stat.full) begin
            cmd = CMD_INSERT;
          end else if (out_free) begin
            load_out   = 1'b1;
            out_status = ST_FULL;
            out_last   = 1'b1;
          end
        end else if (out_free) begin
          load_out   = 1'b1;
          out_last   = 1'b1;
          out_status = stat.found ? ST_CANCELLED : ST_NOT_FOUND;
          cmd        = stat.found ? CMD_REMOVE : CMD_HOLD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_id;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  // Sorted row of pending timers.
  stq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .new_dl (dl_q),
    .new_id (id_q),
    .now    (now),
    .head_id(head_id),
    .stat   (stat)
  );

endmodule

// ===== sv/stq_checker.sv =====
`include "sorted_timer_queue_unit_defines.svh"

module stq_checker
  import stq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [1:0]         s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [ID_BITS-1:0] m_tdata,
  input logic [1:0]         m_tuser,
  input logic               m_tlast
);

  logic held;
  logic req_taken;

  // A result waiting on the receiver, and a request that starts work.
  assign held      = m_tvalid && !m_tready;
  assign req_taken = s_tvalid && s_tready &&
                     ((s_tuser == OP_TICK) || (s_tuser == OP_START) || (s_tuser == OP_CANCEL));

  // A stalled result keeps its contents.
  `STQ_ASSERT_NEXT(a_out_hold, clk, rst, held, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

  // Only expiries can be followed by further results of the same request.
  `STQ_ASSERT_SAME(a_final_status, clk, rst, m_tvalid && (m_tuser != ST_EXPIRED), m_tlast)

  // A valid request is worked on before the next one is taken.
  `STQ_ASSERT_NEXT(a_one_request, clk, rst, req_taken, !s_tready)

  // An idle queue produces no new result.
  `STQ_ASSERT_NEXT(a_idle_quiet, clk, rst, s_tready && !m_tvalid, !m_tvalid)

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

// ===== tb/sorted_timer_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module sorted_timer_queue_unit_tb;
  import stq_pkg::*;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int TIME_BITS   = DEF_TIME_BITS;
  localparam logic [TIME_FIELD_BITS-1:0] TIME_MAX =
    TIME_FIELD_BITS'((64'd1 << TIME_BITS) - 64'd1);

  // Opcode value that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_BITS-1:0] REFRESH_REG_ADDR = {REG_REFRESH, 2'b00};

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic [TIME_FIELD_BITS-1:0] deadline;
    logic [ID_BITS-1:0]         id;
  } timer_slot_t;

  typedef struct {
    logic [ID_BITS-1:0] id;
    status_t            status;
    bit                 is_final;
  } timer_event_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [1:0]               s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [ID_BITS-1:0]       m_tdata;
  logic [1:0]               m_tuser;
  logic                     m_tlast;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Predicted state of the timer list.
  timer_slot_t                armed_timers[$];
  logic [TIME_FIELD_BITS-1:0] stored_now = '0;
  bit                         refresh_mode = 1'b0;

  // Results still owed by the block, oldest first.
  timer_event_t awaited_events[$];
  timer_event_t held_event;
  bit           holding_event = 1'b0;

  logic [TIME_FIELD_BITS-1:0] wall_clock = '0;
  bit          steady_flow = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          status_tally[4] = '{0, 0, 0, 0};

  sorted_timer_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("cycle %0d: mismatch: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one, none while the flow is steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The final flag belongs to the last result of a request, so each result is
  // held back until the next one (or the end of the request) is known.
  function automatic void note_event(input logic [ID_BITS-1:0] id, input status_t st);
    if (holding_event) awaited_events.push_back(held_event);
    held_event.id       = id;
    held_event.status   = st;
    held_event.is_final = 1'b0;
    holding_event       = 1'b1;
  endfunction

  // Load the time and expire every timer strictly before it, front first.
  function automatic void fire_due_timers(input logic [TIME_FIELD_BITS-1:0] t);
    stored_now = t & TIME_MAX;
    while (armed_timers.size() > 0 && armed_timers[0].deadline < stored_now) begin
      note_event(armed_timers[0].id, ST_EXPIRED);
      armed_timers.delete(0);
    end
  endfunction

  function automatic void predict_request(input logic [1:0] op,
                                          input logic [TIME_FIELD_BITS-1:0] t,
                                          input logic [IVL_BITS-1:0] ivl,
                                          input logic [ID_BITS-1:0] id);
    logic [TIME_FIELD_BITS:0] sum;
    timer_slot_t slot;
    int pos;
    holding_event = 1'b0;
    pos = 0;
    case (op)
      OP_TICK: begin
        fire_due_timers(t);
      end
      OP_START: begin
        if (refresh_mode) fire_due_timers(t);
        sum = (TIME_FIELD_BITS+1)'(stored_now) + (TIME_FIELD_BITS+1)'(ivl);
        slot.deadline = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_FIELD_BITS-1:0];
        slot.id = id;
        if (armed_timers.size() >= QUEUE_DEPTH) begin
          note_event(id, ST_FULL);
        end else begin
          // A new timer goes behind any timer with the same deadline.
          while (pos < armed_timers.size() && !(slot.deadline < armed_timers[pos].deadline))
            pos++;
          armed_timers.insert(pos, slot);
        end
      end
      OP_CANCEL: begin
        if (refresh_mode) fire_due_timers(t);
        while (pos < armed_timers.size() && armed_timers[pos].id != id) pos++;
        if (pos < armed_timers.size()) begin
          note_event(id, ST_CANCELLED);
          armed_timers.delete(pos);
        end else begin
          note_event(id, ST_NOT_FOUND);
        end
      end
      default: begin
      end
    endcase
    if (holding_event) begin
      held_event.is_final = 1'b1;
      awaited_events.push_back(held_event);
      holding_event = 1'b0;
    end
  endfunction

  // Offers one request and returns at the edge it is taken, or after a gap.
  task automatic send_request(input logic [1:0] op, input logic [TIME_FIELD_BITS-1:0] t,
                              input logic [IVL_BITS-1:0] ivl, input logic [ID_BITS-1:0] id);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {id, ivl, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(op, t, ivl, id);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_refresh_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REFRESH_REG_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_BITS'(refresh_mode)) begin
      report_mismatch($sformatf("register read %h, want %0d", prdata, refresh_mode));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_refresh_reg(input bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REFRESH_REG_ADDR;
    pwdata  <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    refresh_mode = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_refresh_reg();
  endtask

  function automatic logic [ID_BITS-1:0] pick_req_id();
    if ($urandom_range(0, 9) == 0) return ID_BITS'($urandom);
    return ID_BITS'($urandom_range(0, 31));
  endfunction

  // Mostly plausible traffic with time moving forward, plus a little noise.
  task automatic run_random_traffic(input int count, input int ivl_span);
    logic [1:0]                 op;
    logic [TIME_FIELD_BITS-1:0] t;
    logic [IVL_BITS-1:0]        ivl;
    logic [ID_BITS-1:0]         id;
    int                         r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      wall_clock += TIME_FIELD_BITS'($urandom_range(0, 40));
      t   = wall_clock;
      ivl = $urandom_range(0, ivl_span);
      id  = pick_req_id();
      if (r < 6) begin
        op  = 2'($urandom_range(0, 3));
        t   = {16'($urandom), 32'($urandom)};
        ivl = $urandom;
        id  = ID_BITS'($urandom);
        if (op == OP_TICK || (refresh_mode && op != OP_UNUSED)) wall_clock = t;
      end else if (r < 9) begin
        // Time steps backwards.
        wall_clock = TIME_FIELD_BITS'($urandom_range(0, 5000));
        t  = wall_clock;
        op = OP_TICK;
      end else if (r < 40) begin
        op = OP_TICK;
      end else if (r < 75) begin
        op = OP_START;
        if ($urandom_range(0, 9) == 0) ivl = $urandom;
      end else begin
        op = OP_CANCEL;
        if (armed_timers.size() > 0 && $urandom_range(0, 3) != 0)
          id = armed_timers[$urandom_range(0, armed_timers.size() - 1)].id;
      end
      send_request(op, t, ivl, id);
    end
  endtask

  // Register reset value, ordering of equal deadlines, misses, duplicate ids.
  task automatic test_basic_operations();
    check_refresh_reg();
    drain_results();
    write_refresh_reg(1'b0);
    send_request(OP_TICK, 0, 0, 0);
    send_request(OP_START, 0, 0, 16'h0000);
    send_request(OP_START, 0, 5, 16'hFFFF);
    send_request(OP_START, 0, 5, 16'h1234);
    // Nothing lies strictly below zero.
    send_request(OP_TICK, 0, 0, 0);
    send_request(OP_TICK, 1, 0, 0);
    send_request(OP_TICK, 6, 0, 0);
    send_request(OP_CANCEL, 6, 0, 16'h4321);
    send_request(OP_START, 6, 100, 16'h0007);
    send_request(OP_START, 6, 50, 16'h0007);
    send_request(OP_CANCEL, 6, 0, 16'h0007);
    send_request(OP_TICK, 200, 0, 0);
    send_request(OP_UNUSED, TIME_MAX, '1, '1);
  endtask

  // Deadlines clipped at the top of the time range, then time going back.
  task automatic test_saturation_and_rewind();
    send_request(OP_TICK, TIME_MAX, 0, 0);
    send_request(OP_START, 0, 32'hFFFF_FFFF, 16'hAAAA);
    send_request(OP_START, 0, 1, 16'h5555);
    send_request(OP_TICK, 0, 0, 0);
    send_request(OP_START, 0, 10, 16'h0F0F);
    send_request(OP_TICK, 11, 0, 0);
    send_request(OP_CANCEL, 0, 0, 16'hAAAA);
    send_request(OP_CANCEL, 0, 0, 16'h5555);
    wall_clock = 11;
  endtask

  // Fill the list, overflow it, then one cancel that expires everything first.
  task automatic test_full_list();
    drain_results();
    write_refresh_reg(1'b1);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(OP_START, 1000, IVL_BITS'((i / 2) * 10), ID_BITS'(16'h0100 + i));
    end
    send_request(OP_START, 1000, 3, 16'hBEEF);
    send_request(OP_CANCEL, 5000, 0, 16'h9999);
    send_request(OP_START, 5000, 0, 16'h0003);
    send_request(OP_TICK, 5000, 0, 0);
    wall_clock = 5000;
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    run_random_traffic(40, 2000);
  endtask

  // Short bursts, each followed by a full drain of the results.
  task automatic test_drain_pauses();
    repeat (4) begin
      run_random_traffic(10, 300);
      drain_results();
    end
  endtask

  // Result side pacing, with an occasional long hold-off on request.
  initial begin : result_pacing
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every result transaction is compared with the oldest owed result.
  always @(posedge clk) begin : result_check
    timer_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %h status %0d", m_tdata, m_tuser));
      end else begin
        want = awaited_events.pop_front();
        status_tally[want.status]++;
        if (m_tdata !== want.id)
          report_mismatch($sformatf("result id %h, want %h", m_tdata, want.id));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %0d for id %h, want %0d",
                                    m_tuser, want.id, want.status));
        if (m_tlast !== want.is_final)
          report_mismatch($sformatf("tlast %b for id %h, want %b",
                                    m_tlast, want.id, want.is_final));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_operations();
    test_saturation_and_rewind();
    test_full_list();

    drain_results();
    write_refresh_reg(1'b0);
    steady_flow = 1'b1;
    run_random_traffic(30, 300);
    steady_flow = 1'b0;
    run_random_traffic(70, 300);

    drain_results();
    write_refresh_reg(1'b1);
    run_random_traffic(80, 5000);
    test_output_backpressure();

    drain_results();
    write_refresh_reg(1'b0);
    run_random_traffic(80, 5000);

    drain_results();
    write_refresh_reg(1'b1);
    test_drain_pauses();

    drain_results();
    repeat (20) @(posedge clk);

    $display("Ran %0d requests with refresh on and off, a long result stall and drains.",
             requests_sent);
    $display("Checked %0d results: %0d expired, %0d cancelled, %0d missed, %0d full.",
             results_seen, status_tally[ST_EXPIRED], status_tally[ST_CANCELLED],
             status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/stq_pkg.sv
sv/stq_cell.sv
sv/stq_chain.sv
sv/sorted_timer_queue_unit.sv
sv/stq_checker.sv
tb/sorted_timer_queue_unit_tb.sv
